// ----- src/isc_pkg.sv -----
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the input scan sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

    localparam int NUM_BUTTONS  = 16;
    localparam int NUM_LEDS     = 16;
    localparam int NUM_CHANNELS = 8;
    localparam int RING_DEPTH   = 8;   // power of two: ring pointers wrap naturally

    localparam int BTN_W   = 16;
    localparam int LED_W   = 16;
    localparam int ADC_W   = 10;
    localparam int ACC_W   = 16;
    localparam int MS_W    = 32;
    localparam int PHASE_W = 4;
    localparam int TGT_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CH_W    = $clog2(NUM_CHANNELS);
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);

    localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);
    localparam logic [LED_W-1:0] LED_MASK = LED_W'((64'd1 << NUM_LEDS) - 64'd1);

    localparam logic [PHASE_W-1:0] DIVIDER_RESET = 4'd4;
    localparam logic [TGT_W-1:0]   TARGET_RESET  = 7'd16;

    // configuration register indexes
    localparam logic CFG_TICK_DIVIDER  = 1'b0;
    localparam logic CFG_SAMPLE_TARGET = 1'b1;

    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_CONV_DONE = 3'd1,
        FUNC_POP       = 3'd2,
        FUNC_READ_ACC  = 3'd3,
        FUNC_RESTART   = 3'd4
    } t_func;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [RING_AW-1:0] wr_addr;
        logic [RING_AW-1:0] rd_addr;
        logic [BTN_W-1:0]   wr_data;
    } t_ring_req;

    typedef struct packed {
        logic             add;
        logic             rd;
        logic             clr;
        logic [CH_W-1:0]  addr;
        logic [ADC_W-1:0] adc;
    } t_acc_cmd;

    typedef struct packed {
        logic             start_conversion;
        logic [2:0]       adc_channel;
        logic [LED_W-1:0] led_drive;
        logic [LED_W-1:0] led_changed;
        logic [MS_W-1:0]  ms_time;
        logic [3:0]       buffer_count;
        logic             sampling_done;
        logic             pop_ok;
        t_acc_cmd         acc;
    } t_s1;

    typedef struct packed {
        logic             start_conversion;
        logic [2:0]       adc_channel;
        logic [LED_W-1:0] led_drive;
        logic [LED_W-1:0] led_changed;
        logic [MS_W-1:0]  ms_time;
        logic [BTN_W-1:0] snapshot;
        logic             snapshot_valid;
        logic [3:0]       buffer_count;
        logic             sampling_done;
        logic [ACC_W-1:0] accum_value;
    } t_result;

endpackage

`default_nettype wire

// ----- src/input_scan_sampler.sv -----
// ----------------------------------------------------------------------------
// input_scan_sampler
// Control surface scan controller: tick, conversion and consumer operations.
// ----------------------------------------------------------------------------
// Takes one operation per clock and keeps that rate under steady traffic
// while i_stall is low; each result passes through the work stage and then
// the result register. On transfer the scan counters update and the read of
// the accumulator RAM or the snapshot RAM (a registered read) is issued; the
// work stage adds the sample and writes the accumulator back, with the
// previous write bypassed when the same channel follows back to back, and
// loads the result register. Accumulator clearing uses per-channel valid
// bits, so no clearing pass follows reset or a restart. The result register
// lets the next operation in while a result is held off by o_valid/i_stall.
`default_nettype none

module input_scan_sampler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [15:0] i_button_levels,
    input  wire logic [15:0] i_led_states,
    input  wire logic [9:0]  i_adc_value,
    input  wire logic [2:0]  i_read_channel,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_start_conversion,
    output logic [2:0]       o_adc_channel,
    output logic [15:0]      o_led_drive,
    output logic [15:0]      o_led_changed,
    output logic [31:0]      o_ms_time,
    output logic [15:0]      o_snapshot,
    output logic             o_snapshot_valid,
    output logic [3:0]       o_buffer_count,
    output logic             o_sampling_done,
    output logic [15:0]      o_accum_value,

    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [6:0]  i_cfg_wdata
);
    import isc_pkg::*;

    logic             accept;
    logic             s1_adv;
    logic             r_s1_valid;
    logic             r_o_valid;
    t_result          r_out;
    t_ring_req        ring_req;
    logic             acc_rd_en;
    logic [CH_W-1:0]  acc_rd_addr;
    t_s1              s1;
    logic [BTN_W-1:0] ring_q;
    logic [ACC_W-1:0] acc_value;

    assign s1_adv  = r_s1_valid & (~r_o_valid | ~i_stall);
    assign o_stall = r_s1_valid & ~s1_adv;
    assign accept  = i_valid & ~o_stall;

    isc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_func          (i_func),
        .i_button_levels (i_button_levels),
        .i_led_states    (i_led_states),
        .i_adc_value     (i_adc_value),
        .i_read_channel  (i_read_channel),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_ring_req      (ring_req),
        .o_acc_rd_en     (acc_rd_en),
        .o_acc_rd_addr   (acc_rd_addr),
        .o_s1            (s1)
    );

    isc_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (ring_q)
    );

    isc_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc_rd_en),
        .i_rd_addr (acc_rd_addr),
        .i_adv     (s1_adv),
        .i_cmd     (s1.acc),
        .o_value   (acc_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.start_conversion <= s1.start_conversion;
            r_out.adc_channel      <= s1.adc_channel;
            r_out.led_drive        <= s1.led_drive;
            r_out.led_changed      <= s1.led_changed;
            r_out.ms_time          <= s1.ms_time;
            r_out.snapshot         <= s1.pop_ok ? ring_q : '0;
            r_out.snapshot_valid   <= s1.pop_ok;
            r_out.buffer_count     <= s1.buffer_count;
            r_out.sampling_done    <= s1.sampling_done;
            r_out.accum_value      <= acc_value;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_start_conversion = r_out.start_conversion;
    assign o_adc_channel      = r_out.adc_channel;
    assign o_led_drive        = r_out.led_drive;
    assign o_led_changed      = r_out.led_changed;
    assign o_ms_time          = r_out.ms_time;
    assign o_snapshot         = r_out.snapshot;
    assign o_snapshot_valid   = r_out.snapshot_valid;
    assign o_buffer_count     = r_out.buffer_count;
    assign o_sampling_done    = r_out.sampling_done;
    assign o_accum_value      = r_out.accum_value;

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("input stalled with empty work stage");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_o_valid)
        else $error("advanced item missing from result register");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("transferred item missing from work stage");

endmodule

`default_nettype wire

// ----- src/isc_ring.sv -----
// ----------------------------------------------------------------------------
// isc_ring
// Button snapshot ring storage: one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_ring (
    input  wire logic                i_clk,
    input  wire isc_pkg::t_ring_req  i_req,
    output logic [isc_pkg::BTN_W-1:0] o_rd_data
);
    import isc_pkg::*;

    logic [BTN_W-1:0] r_mem [RING_DEPTH];
    logic [BTN_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.pop) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/isc_accum.sv -----
// ----------------------------------------------------------------------------
// isc_accum
// Per-channel accumulators: synchronous RAM, read-modify-write with a
// registered read, valid bits for the zero state, bypass of the previous write.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_accum (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_rd_en,
    input  wire logic [isc_pkg::CH_W-1:0] i_rd_addr,
    input  wire logic                    i_adv,
    input  wire isc_pkg::t_acc_cmd       i_cmd,
    output logic [isc_pkg::ACC_W-1:0]    o_value
);
    import isc_pkg::*;

    logic [ACC_W-1:0]        r_mem [NUM_CHANNELS];
    logic [ACC_W-1:0]        r_q;
    logic [NUM_CHANNELS-1:0] r_vld;
    logic                    r_fwd_vld;
    logic [CH_W-1:0]         r_fwd_addr;
    logic [ACC_W-1:0]        r_fwd_data;

    logic [ACC_W-1:0] old_val;
    logic [ACC_W-1:0] sum;

    // the RAM read in flight may have missed the write done on the same edge
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == i_cmd.addr)) begin
            old_val = r_fwd_data;
        end else if (r_vld[i_cmd.addr]) begin
            old_val = r_q;
        end else begin
            old_val = '0;
        end
        sum     = old_val + ACC_W'(i_cmd.adc);
        o_value = i_cmd.rd ? old_val : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
        if (i_adv && i_cmd.add) begin
            r_mem[i_cmd.addr] <= sum;
        end
        if (i_adv) begin
            r_fwd_addr <= i_cmd.addr;
            r_fwd_data <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_adv) begin
            r_fwd_vld <= i_cmd.add;
            if (i_cmd.clr) begin
                r_vld <= '0;
            end else if (i_cmd.add) begin
                r_vld[i_cmd.addr] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/isc_ctrl.sv -----
// ----------------------------------------------------------------------------
// isc_ctrl
// Scalar scan state, config registers and request issue for the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [2:0]               i_func,
    input  wire logic [isc_pkg::BTN_W-1:0] i_button_levels,
    input  wire logic [isc_pkg::LED_W-1:0] i_led_states,
    input  wire logic [isc_pkg::ADC_W-1:0] i_adc_value,
    input  wire logic [2:0]               i_read_channel,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_addr,
    input  wire logic [isc_pkg::CFG_W-1:0] i_cfg_wdata,
    output isc_pkg::t_ring_req            o_ring_req,
    output logic                          o_acc_rd_en,
    output logic [isc_pkg::CH_W-1:0]      o_acc_rd_addr,
    output isc_pkg::t_s1                  o_s1
);
    import isc_pkg::*;

    logic [PHASE_W-1:0] r_divider;
    logic [TGT_W-1:0]   r_target;

    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [MS_W-1:0]    r_millis, n_millis;
    logic [LED_W-1:0]   r_led,    n_led;
    logic [RING_AW-1:0] r_head,   n_head;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [CH_W-1:0]    r_chan,   n_chan;
    logic [TGT_W-1:0]   r_sweep,  n_sweep;
    t_s1                r_s1,     n_s1;

    logic [PHASE_W-1:0] phase_inc;
    logic [RING_AW-1:0] tail;
    t_ring_req          ring;
    t_acc_cmd           acc;
    logic [LED_W-1:0]   changed;
    logic               start;
    logic               pop_ok;

    always_comb begin
        n_phase  = r_phase;
        n_millis = r_millis;
        n_led    = r_led;
        n_head   = r_head;
        n_count  = r_count;
        n_chan   = r_chan;
        n_sweep  = r_sweep;
        changed  = '0;
        start    = 1'b0;
        pop_ok   = 1'b0;
        ring     = '0;
        acc      = '0;
        acc.adc  = i_adc_value;
        phase_inc = r_phase + 1'b1;
        // oldest entry; a full ring has count bits zero below the top
        tail     = r_head + 1'b1 - r_count[RING_AW-1:0];

        case (i_func)
            FUNC_TICK: begin
                start = (r_sweep < r_target);
                if (phase_inc >= r_divider) begin
                    n_phase  = '0;
                    changed  = (i_led_states & LED_MASK) ^ r_led;
                    n_led    = i_led_states & LED_MASK;
                    n_millis = r_millis + 1'b1;
                    if (r_count < CNT_W'(RING_DEPTH)) begin
                        n_head       = r_head + 1'b1;
                        n_count      = r_count + 1'b1;
                        ring.push    = 1'b1;
                        ring.wr_addr = r_head + 1'b1;
                        ring.wr_data = ~i_button_levels & BTN_MASK;
                    end
                end else begin
                    n_phase = phase_inc;
                end
            end
            FUNC_CONV_DONE: begin
                acc.add  = 1'b1;
                acc.addr = r_chan;
                if (r_chan == CH_W'(NUM_CHANNELS - 1)) begin
                    n_chan = '0;
                    if (r_sweep < r_target) begin
                        n_sweep = r_sweep + 1'b1;
                    end
                end else begin
                    n_chan = r_chan + 1'b1;
                end
            end
            FUNC_POP: begin
                if (r_count != '0) begin
                    pop_ok       = 1'b1;
                    ring.pop     = 1'b1;
                    ring.rd_addr = tail;
                    n_count      = r_count - 1'b1;
                end
            end
            FUNC_READ_ACC: begin
                acc.rd   = 1'b1;
                acc.addr = CH_W'(i_read_channel);
            end
            FUNC_RESTART: begin
                acc.clr = 1'b1;
                n_sweep = '0;
            end
            default: begin
            end
        endcase

        n_s1.start_conversion = start;
        n_s1.adc_channel      = 3'(n_chan);
        n_s1.led_drive        = n_led;
        n_s1.led_changed      = changed;
        n_s1.ms_time          = n_millis;
        n_s1.buffer_count     = 4'(n_count);
        n_s1.sampling_done    = (n_sweep >= r_target);
        n_s1.pop_ok           = pop_ok;
        n_s1.acc              = acc;
    end

    always_comb begin
        o_ring_req      = ring;
        o_ring_req.push = ring.push & i_accept;
        o_ring_req.pop  = ring.pop & i_accept;
        o_acc_rd_en     = i_accept & (acc.add | acc.rd);
        o_acc_rd_addr   = acc.addr;
        o_s1            = r_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= DIVIDER_RESET;
            r_target  <= TARGET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TICK_DIVIDER:  r_divider <= i_cfg_wdata[PHASE_W-1:0];
                CFG_SAMPLE_TARGET: r_target  <= i_cfg_wdata[TGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_millis <= '0;
            r_led    <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_chan   <= '0;
            r_sweep  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_millis <= n_millis;
            r_led    <= n_led;
            r_head   <= n_head;
            r_count  <= n_count;
            r_chan   <= n_chan;
            r_sweep  <= n_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    a_ring_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH))
        else $error("ring count above depth");

endmodule

`default_nettype wire
